// ----- hdl/vfc_pkg.sv -----
// Shared types and constants for the voxel face culling unit.
// No dependencies; the two interfaces and the culling unit refer to this package.
package vfc_pkg;

    localparam int COORD_W = 5;
    localparam int VALUE_W = 8;
    localparam int DIR_W   = 3;

    typedef logic signed [COORD_W-1:0] coord_s_t;
    typedef logic        [COORD_W-1:0] coord_u_t;
    typedef logic        [VALUE_W-1:0] value_t;
    typedef logic        [DIR_W-1:0]   dir_t;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Face directions, in emission order.
    localparam dir_t DIR_LEFT    = 3'd0;
    localparam dir_t DIR_RIGHT   = 3'd1;
    localparam dir_t DIR_FORWARD = 3'd2;
    localparam dir_t DIR_BACK    = 3'd3;
    localparam dir_t DIR_UP      = 3'd4;
    localparam dir_t DIR_DOWN    = 3'd5;
    localparam int   NUM_DIRS    = 6;

endpackage

// ----- hdl/vfc_req_if.sv -----
// Request channel of the voxel face culling unit: valid/ready plus payload.
// Depends on vfc_pkg for the field types.
interface vfc_req_if;
    logic              valid;
    logic              ready;
    logic              req_type;
    vfc_pkg::coord_s_t voxel_x;
    vfc_pkg::coord_u_t voxel_y;
    vfc_pkg::coord_s_t voxel_z;
    vfc_pkg::value_t   voxel_value;

    modport source (output valid, req_type, voxel_x, voxel_y, voxel_z, voxel_value,
                    input ready);
    modport sink   (input valid, req_type, voxel_x, voxel_y, voxel_z, voxel_value,
                    output ready);
endinterface

// ----- hdl/vfc_face_if.sv -----
// Face record channel of the voxel face culling unit: valid/ready plus payload.
// Depends on vfc_pkg for the field types.
interface vfc_face_if;
    logic              valid;
    logic              ready;
    vfc_pkg::coord_s_t face_x;
    vfc_pkg::coord_u_t face_y;
    vfc_pkg::coord_s_t face_z;
    vfc_pkg::dir_t     face_dir;
    logic              face_valid;
    logic              last;

    modport source (output valid, face_x, face_y, face_z, face_dir, face_valid, last,
                    input ready);
    modport sink   (input valid, face_x, face_y, face_z, face_dir, face_valid, last,
                     output ready);
endinterface

// ----- hdl/vfc_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/voxel_face_culling_unit.sv -----
// Voxel face culling unit: a SIZE^3 voxel store in one single-port RAM.
// A write request gives no record.
// A query gives n records (n is 1 to 6): it scans the centre voxel and its six neighbours,
// with up to seven voxel reads, one a cycle through the single RAM port, then one record
// per cycle while the record side is ready.
// Reset clears the control state; the voxel store is undefined until written.
module voxel_face_culling_unit #(
    parameter int SIZE = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    vfc_req_if.sink        req,
    vfc_face_if.source     face
);

    localparam int CW    = $clog2(SIZE);
    localparam int DEPTH = SIZE * SIZE * SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = SIZE / 2;
    // Offset coordinates span HALF-17 .. HALF+16, plus a sign bit.
    localparam int IW    = $clog2(HALF + 17) + 2;
    localparam logic signed [IW-1:0] SIZE_S = IW'(SIZE);
    localparam logic        [AW-1:0] ROW    = AW'(SIZE);
    localparam logic        [AW-1:0] PLANE  = AW'(SIZE * SIZE);
    localparam logic        [2:0]    LAST_STEP = 3'(vfc_pkg::NUM_DIRS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MASK  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    typedef logic signed [IW-1:0] ofs_t;

    function automatic logic in_chunk(input ofs_t a, input ofs_t b, input ofs_t c);
        return (a >= 0) && (a < SIZE_S) && (b >= 0) && (b < SIZE_S)
            && (c >= 0) && (c < SIZE_S);
    endfunction

    function automatic logic [AW-1:0] voxel_index(input ofs_t a, input ofs_t b,
                                                  input ofs_t c);
        return AW'(a[CW-1:0]) + AW'(b[CW-1:0]) * ROW + AW'(c[CW-1:0]) * PLANE;
    endfunction

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       rd_pend_reg, rd_pend_next;
    logic [2:0] rd_step_reg, rd_step_next;
    logic       out_valid_reg, out_valid_next;

    ofs_t cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    vfc_pkg::coord_s_t qx_reg, qx_next, qz_reg, qz_next;
    vfc_pkg::coord_u_t qy_reg, qy_next;
    // Bit 0 is the centre voxel being nonzero; bits 1..6 are neighbours being solid.
    logic [6:0] solid_reg, solid_next;
    logic [5:0] rem_reg, rem_next;

    // The record coordinates have their own registers, so a new query can be
    // taken while the final record of the previous one still waits.
    vfc_pkg::coord_s_t fx_reg, fx_next, fz_reg, fz_next;
    vfc_pkg::coord_u_t fy_reg, fy_next;
    vfc_pkg::dir_t dir_reg, dir_next;
    logic          fvalid_reg, fvalid_next;
    logic          last_reg, last_next;

    ofs_t in_x, in_y, in_z;
    ofs_t px, py, pz;
    ofs_t dx, dy, dz;
    logic in_ok;
    logic accept;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    vfc_pkg::value_t ram_rdata;

    logic [2:0] low_dir;
    logic [5:0] rest;

    assign in_x   = IW'(req.voxel_x) + IW'(HALF);
    assign in_y   = IW'(req.voxel_y);
    assign in_z   = IW'(req.voxel_z) + IW'(HALF);
    assign in_ok  = in_chunk(in_x, in_y, in_z);
    assign req.ready = (state_reg == ST_IDLE);
    assign accept = req.valid && req.ready;

    // Neighbour offsets for each scan step; step zero reads the centre.
    always_comb
    begin
        dx = '0;
        dy = '0;
        dz = '0;
        case (step_reg)
            3'd1:    dx = ofs_t'(-1);
            3'd2:    dx = ofs_t'(1);
            3'd3:    dz = ofs_t'(-1);
            3'd4:    dz = ofs_t'(1);
            3'd5:    dy = ofs_t'(-1);
            3'd6:    dy = ofs_t'(1);
            default: ;
        endcase
    end

    assign px = cx_reg + dx;
    assign py = cy_reg + dy;
    assign pz = cz_reg + dz;

    always_comb
    begin
        low_dir = '0;
        for (int i = vfc_pkg::NUM_DIRS - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                low_dir = 3'(i);
            end
        end
        rest = rem_reg & ~(6'b1 << low_dir);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rd_pend_next   = 1'b0;
        rd_step_next   = rd_step_reg;
        out_valid_next = out_valid_reg && !face.ready;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        solid_next     = solid_reg;
        rem_next       = rem_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        fz_next        = fz_reg;
        dir_next       = dir_reg;
        fvalid_next    = fvalid_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_addr       = voxel_index(px, py, pz);

        // Read data returns in the cycle after the address was issued.
        if (rd_pend_reg)
        begin
            solid_next[rd_step_reg] = (ram_rdata != '0);
        end

        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = voxel_index(in_x, in_y, in_z);
                if (accept)
                begin
                    if (req.req_type == vfc_pkg::REQ_WRITE)
                    begin
                        ram_we = in_ok;
                    end
                    else
                    begin
                        cx_next    = in_x;
                        cy_next    = in_y;
                        cz_next    = in_z;
                        qx_next    = req.voxel_x;
                        qy_next    = req.voxel_y;
                        qz_next    = req.voxel_z;
                        solid_next = '0;
                        step_next  = '0;
                        // A query outside the chunk behaves as an empty voxel.
                        state_next = in_ok ? ST_SCAN : ST_MASK;
                    end
                end
            end
            ST_SCAN:
            begin
                if (in_chunk(px, py, pz))
                begin
                    rd_pend_next = 1'b1;
                    rd_step_next = step_reg;
                end
                else
                begin
                    solid_next[step_reg] = 1'b1;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MASK;
            end
            ST_MASK:
            begin
                rem_next   = solid_reg[0] ? ~solid_reg[6:1] : '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || face.ready)
                begin
                    out_valid_next = 1'b1;
                    fx_next        = qx_reg;
                    fy_next        = qy_reg;
                    fz_next        = qz_reg;
                    if (rem_reg == '0)
                    begin
                        dir_next    = vfc_pkg::DIR_LEFT;
                        fvalid_next = 1'b0;
                        last_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        dir_next    = low_dir;
                        fvalid_next = 1'b1;
                        last_next   = (rest == '0);
                        rem_next    = rest;
                        if (rest == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            rd_step_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_pend_reg   <= rd_pend_next;
            rd_step_reg   <= rd_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        qz_reg     <= qz_next;
        solid_reg  <= solid_next;
        rem_reg    <= rem_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        fz_reg     <= fz_next;
        dir_reg    <= dir_next;
        fvalid_reg <= fvalid_next;
        last_reg   <= last_next;
    end

    vfc_ram #(
        .WIDTH (vfc_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.voxel_value),
        .rdata (ram_rdata)
    );

    assign face.valid      = out_valid_reg;
    assign face.face_x     = fx_reg;
    assign face.face_y     = fy_reg;
    assign face.face_z     = fz_reg;
    assign face.face_dir   = dir_reg;
    assign face.face_valid = fvalid_reg;
    assign face.last       = last_reg;

endmodule
